FILE: rtl/ata_brtg_pkg.sv
// package for the ata block request task-file generator
// holds payload structs, config struct, codes and command constants
// no dependencies
package ata_brtg_pkg;

    localparam int DIV_W = 32;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // configuration register indexes
    localparam logic [2:0] CFG_USE_LBA  = 3'd0;
    localparam logic [2:0] CFG_SPT      = 3'd1;
    localparam logic [2:0] CFG_HEADS    = 3'd2;
    localparam logic [2:0] CFG_SLAVE    = 3'd3;
    localparam logic [2:0] CFG_KIND     = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_REFUSED  = 2'd1;
    localparam logic [1:0] ST_CYL_OVF  = 2'd2;

    // task-file constants
    localparam logic [7:0]  CMD_READ    = 8'h20;
    localparam logic [7:0]  CMD_WRITE   = 8'h30;
    localparam logic [7:0]  CMD_PACKET  = 8'hA0;
    localparam logic [7:0]  DH_BASE     = 8'hA0;
    localparam logic [7:0]  DH_LBA      = 8'h40;
    localparam logic [7:0]  DH_SLAVE    = 8'h10;
    localparam logic [15:0] ATAPI_BYTES = 16'd2048;

    // request kind after classification
    localparam logic JOB_NORMAL = 1'b0;
    localparam logic JOB_REFUSE = 1'b1;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic KIND_ATA   = 1'b0;
    localparam logic KIND_ATAPI = 1'b1;

    typedef struct packed {
        logic        op;
        logic [31:0] start_block;
        logic [6:0]  block_count;
    } t_request;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  command;
        logic [7:0]  sector_number;
        logic [15:0] cylinder;
        logic [7:0]  drive_head;
        logic [31:0] packet_block;
        logic        last;
    } t_result;

    typedef struct packed {
        logic        use_lba;
        logic [7:0]  track_sectors;
        logic [4:0]  head_count;
        logic        device_is_slave;
        logic        device_kind;
    } t_cfg;

    typedef struct packed {
        logic        kind;
        logic        op;
        logic [31:0] start_block;
        logic [6:0]  block_count;
    } t_job;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [7:0]       divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [7:0]       remainder;
    } t_div_rsp;

endpackage

FILE: rtl/ata_brtg_fifo.sv
// small register queue with first-word fall-through read
// generic in width and depth, no package dependency
module ata_brtg_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/ata_brtg_front.sv
// front end: classifies each accepted request into a job for the queue
// drops empty requests, clamps the count, marks atapi writes as refused
// depends on ata_brtg_pkg
module ata_brtg_front #(
    parameter int MAX_BLOCKS = 64
) (
    input  logic                  i_accept,
    input  ata_brtg_pkg::t_request i_req,
    input  logic                  i_device_kind,
    output logic                  o_wr,
    output ata_brtg_pkg::t_job    o_job
);

    logic [6:0] count_clamped;

    always_comb begin
        count_clamped = (i_req.block_count > 7'(MAX_BLOCKS)) ? 7'(MAX_BLOCKS)
                                                             : i_req.block_count;
        o_wr              = i_accept && (i_req.block_count != 7'd0);
        o_job.op          = i_req.op;
        o_job.start_block = i_req.start_block;
        o_job.block_count = count_clamped;
        if (i_device_kind == ata_brtg_pkg::KIND_ATAPI && i_req.op == ata_brtg_pkg::OP_WRITE) begin
            o_job.kind = ata_brtg_pkg::JOB_REFUSE;
        end else begin
            o_job.kind = ata_brtg_pkg::JOB_NORMAL;
        end
    end

endmodule

FILE: rtl/ata_brtg_div.sv
// radix-2 restoring divider, 32-bit dividend by 8-bit divisor
// one quotient bit per cycle; depends on ata_brtg_pkg
module ata_brtg_div (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ata_brtg_pkg::t_div_req i_req,
    output ata_brtg_pkg::t_div_rsp o_rsp
);

    localparam int W = ata_brtg_pkg::DIV_W;
    localparam int CW = ata_brtg_pkg::DIV_CNT_W;

    logic [W-1:0]  r_quo;
    logic [7:0]    r_rem;
    logic [7:0]    r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [8:0]    trial;
    logic [8:0]    diff;
    logic          ge;
    logic [7:0]    n_rem;

    always_comb begin
        trial = {r_rem, r_quo[W-1]};
        diff  = trial - {1'b0, r_den};
        ge    = (trial >= {1'b0, r_den});
        n_rem = ge ? diff[7:0] : trial[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy      = r_busy;
    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

FILE: rtl/ata_brtg_back.sv
// back end: walks the blocks of one job and builds a task-file per block
// chs addresses go through the shared divider twice; depends on ata_brtg_pkg
module ata_brtg_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ata_brtg_pkg::t_cfg     i_cfg,
    input  logic                   i_job_empty,
    input  ata_brtg_pkg::t_job     i_job,
    output logic                   o_job_pop,
    output ata_brtg_pkg::t_div_req o_div_req,
    input  ata_brtg_pkg::t_div_rsp i_div_rsp,
    input  logic                   i_res_full,
    output logic                   o_res_push,
    output ata_brtg_pkg::t_result  o_res
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_NEXT = 3'd1;
    localparam logic [2:0] S_DIV1 = 3'd2;
    localparam logic [2:0] S_DIV2 = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0]  r_state;
    logic [2:0]  n_state;
    logic        r_kind;
    logic        r_op;
    logic [31:0] r_addr;
    logic [6:0]  r_left;
    logic [7:0]  r_sec;
    logic [3:0]  r_head;
    logic [15:0] r_cyl;
    logic        r_ovf;
    logic [7:0]  spt_eff;
    logic [4:0]  hds_eff;
    logic        direct;
    logic [7:0]  slave_bit;
    logic        is_last;

    always_comb begin
        spt_eff   = (i_cfg.track_sectors == 8'd0) ? 8'd1 : i_cfg.track_sectors;
        hds_eff   = (i_cfg.head_count == 5'd0) ? 5'd1 : i_cfg.head_count;
        direct    = (i_cfg.device_kind == ata_brtg_pkg::KIND_ATAPI) || i_cfg.use_lba;
        slave_bit = i_cfg.device_is_slave ? ata_brtg_pkg::DH_SLAVE : 8'h00;
        is_last   = (r_left == 7'd1);
    end

    // result fields for the current block
    always_comb begin
        o_res = '0;
        o_res.last = is_last || (r_kind == ata_brtg_pkg::JOB_REFUSE);
        if (r_kind == ata_brtg_pkg::JOB_REFUSE) begin
            o_res.status = ata_brtg_pkg::ST_REFUSED;
        end else if (i_cfg.device_kind == ata_brtg_pkg::KIND_ATAPI) begin
            o_res.status       = ata_brtg_pkg::ST_OK;
            o_res.command      = ata_brtg_pkg::CMD_PACKET;
            o_res.cylinder     = ata_brtg_pkg::ATAPI_BYTES;
            o_res.drive_head   = ata_brtg_pkg::DH_BASE | ata_brtg_pkg::DH_LBA | slave_bit;
            o_res.packet_block = r_addr;
        end else begin
            o_res.command = (r_op == ata_brtg_pkg::OP_WRITE) ? ata_brtg_pkg::CMD_WRITE
                                                             : ata_brtg_pkg::CMD_READ;
            if (i_cfg.use_lba) begin
                o_res.status        = ata_brtg_pkg::ST_OK;
                o_res.sector_number = r_addr[7:0];
                o_res.cylinder      = r_addr[23:8];
                o_res.drive_head    = ata_brtg_pkg::DH_BASE | ata_brtg_pkg::DH_LBA | slave_bit
                                      | {4'h0, r_addr[27:24]};
            end else begin
                o_res.status        = r_ovf ? ata_brtg_pkg::ST_CYL_OVF : ata_brtg_pkg::ST_OK;
                o_res.sector_number = r_sec;
                o_res.cylinder      = r_cyl;
                o_res.drive_head    = ata_brtg_pkg::DH_BASE | slave_bit | {4'h0, r_head};
            end
        end
    end

    always_comb begin
        n_state             = r_state;
        o_job_pop           = 1'b0;
        o_res_push          = 1'b0;
        o_div_req.start     = 1'b0;
        o_div_req.dividend  = r_addr;
        o_div_req.divisor   = spt_eff;
        unique case (r_state)
            S_IDLE: begin
                if (!i_job_empty) begin
                    o_job_pop = 1'b1;
                    n_state   = S_NEXT;
                end
            end
            S_NEXT: begin
                if (r_kind == ata_brtg_pkg::JOB_REFUSE || direct) begin
                    n_state = S_EMIT;
                end else if (!i_div_rsp.busy) begin
                    o_div_req.start = 1'b1;
                    n_state         = S_DIV1;
                end
            end
            S_DIV1: begin
                // quotient of the first pass feeds the head/cylinder split
                o_div_req.dividend = i_div_rsp.quotient;
                o_div_req.divisor  = {3'b000, hds_eff};
                if (i_div_rsp.done) begin
                    o_div_req.start = 1'b1;
                    n_state         = S_DIV2;
                end
            end
            S_DIV2: begin
                if (i_div_rsp.done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    if (r_kind == ata_brtg_pkg::JOB_REFUSE || is_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_NEXT;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_kind <= i_job.kind;
            r_op   <= i_job.op;
            r_addr <= i_job.start_block;
            r_left <= i_job.block_count;
        end else if (o_res_push) begin
            r_addr <= r_addr + 32'd1;
            r_left <= r_left - 7'd1;
        end
        if (r_state == S_DIV1 && i_div_rsp.done) begin
            r_sec <= i_div_rsp.remainder + 8'd1;
        end
        if (r_state == S_DIV2 && i_div_rsp.done) begin
            r_head <= i_div_rsp.remainder[3:0];
            r_cyl  <= i_div_rsp.quotient[15:0];
            r_ovf  <= |i_div_rsp.quotient[31:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/ata_block_request_taskfile_gen.sv
// Task-file generator for ATA/ATAPI block requests. A request (read or write,
// start block, count) is taken whenever the two-entry request queue has room,
// so push is not held off while earlier requests are still being expanded.
// Requests are then worked one at a time, one descriptor per block, the last
// one marked. In LBA or ATAPI mode a descriptor passes through a next and an emit
// state and the divider is not used. In CHS mode each descriptor takes two passes of
// the single one-bit-per-cycle divider (address by sectors per track, then by head
// count) between a setup state and an emit state. A two-entry result queue sits
// before the output ports. A request with a zero count is accepted and produces
// nothing; an ATAPI write produces one refusal result. Configuration must be
// written only while the block is idle; the block itself does not enforce this.
// depends on ata_brtg_pkg, ata_brtg_fifo, ata_brtg_front, ata_brtg_div, ata_brtg_back
module ata_block_request_taskfile_gen #(
    parameter int MAX_BLOCKS = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  ata_brtg_pkg::t_request i_req,
    output logic                   empty,
    input  logic                   pop,
    output ata_brtg_pkg::t_result  o_res,
    input  logic                   i_cfg_we,
    input  logic [2:0]             i_cfg_idx,
    input  logic [7:0]             i_cfg_wdata
);

    ata_brtg_pkg::t_cfg     r_cfg;
    ata_brtg_pkg::t_job     front_job;
    ata_brtg_pkg::t_job     back_job;
    ata_brtg_pkg::t_div_req div_req;
    ata_brtg_pkg::t_div_rsp div_rsp;
    ata_brtg_pkg::t_result  back_res;
    logic                   front_wr;
    logic                   job_empty;
    logic                   job_pop;
    logic                   res_full;
    logic                   res_push;
    logic [$bits(ata_brtg_pkg::t_job)-1:0]    job_rd_data;
    logic [$bits(ata_brtg_pkg::t_result)-1:0] res_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.use_lba           <= 1'b0;
            r_cfg.track_sectors     <= 8'd63;
            r_cfg.head_count        <= 5'd16;
            r_cfg.device_is_slave   <= 1'b0;
            r_cfg.device_kind       <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ata_brtg_pkg::CFG_USE_LBA: r_cfg.use_lba           <= i_cfg_wdata[0];
                ata_brtg_pkg::CFG_SPT:     r_cfg.track_sectors     <= i_cfg_wdata;
                ata_brtg_pkg::CFG_HEADS:   r_cfg.head_count        <= i_cfg_wdata[4:0];
                ata_brtg_pkg::CFG_SLAVE:   r_cfg.device_is_slave   <= i_cfg_wdata[0];
                ata_brtg_pkg::CFG_KIND:    r_cfg.device_kind       <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    ata_brtg_front #(
        .MAX_BLOCKS(MAX_BLOCKS)
    ) u_front (
        .i_accept      (push && !full),
        .i_req         (i_req),
        .i_device_kind (r_cfg.device_kind),
        .o_wr          (front_wr),
        .o_job         (front_job)
    );

    ata_brtg_fifo #(
        .WIDTH($bits(ata_brtg_pkg::t_job)),
        .DEPTH(2)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_wr),
        .i_data  (front_job),
        .o_full  (full),
        .i_pop   (job_pop),
        .o_data  (job_rd_data),
        .o_empty (job_empty)
    );

    assign back_job = ata_brtg_pkg::t_job'(job_rd_data);

    ata_brtg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    ata_brtg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_empty (job_empty),
        .i_job       (back_job),
        .o_job_pop   (job_pop),
        .o_div_req   (div_req),
        .i_div_rsp   (div_rsp),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (back_res)
    );

    ata_brtg_fifo #(
        .WIDTH($bits(ata_brtg_pkg::t_result)),
        .DEPTH(2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_rd_data),
        .o_empty (empty)
    );

    assign o_res = ata_brtg_pkg::t_result'(res_rd_data);

endmodule

FILE: rtl/ata_brtg_chk.sv
// port-level checker for the task-file generator, bound to the top level
// depends on ata_brtg_pkg and ata_block_request_taskfile_gen
module ata_brtg_chk (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  empty,
    input logic                  pop,
    input ata_brtg_pkg::t_result o_res
);

    // nothing can be waiting right after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result visible after reset");

    // a waiting request result holds until taken
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_res)))
        else $error("waiting result changed");

    // a refusal is a single, empty, final result
    a_refusal_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_res.status == ata_brtg_pkg::ST_REFUSED) |->
        (o_res.last && o_res.command == 8'h00 && o_res.packet_block == 32'd0))
        else $error("malformed refusal");

    // accepted results carry a known command
    a_known_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_res.status != ata_brtg_pkg::ST_REFUSED) |->
        (o_res.command == ata_brtg_pkg::CMD_READ || o_res.command == ata_brtg_pkg::CMD_WRITE
         || o_res.command == ata_brtg_pkg::CMD_PACKET))
        else $error("unknown command code");

    // packet descriptors always carry the fixed byte count
    a_packet_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_res.command == ata_brtg_pkg::CMD_PACKET) |->
        (o_res.cylinder == ata_brtg_pkg::ATAPI_BYTES && o_res.status == ata_brtg_pkg::ST_OK))
        else $error("bad packet descriptor");

endmodule

bind ata_block_request_taskfile_gen ata_brtg_chk u_chk (.*);

FILE: tb/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for ata_block_request_taskfile_gen: requests go in through a queue
// port and each task-file descriptor is checked against a predictor kept in this file
// depends on ata_brtg_pkg and the block's rtl
module tb;

    localparam int MAX_REQ_BLOCKS = 64;
    localparam int LONG_STALL_CYCLES = 400;
    localparam int DRAIN_CYCLES = 150;
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    logic                   i_clk;
    logic                   i_rst_n = 1'b0;
    logic                   push = 1'b0;
    logic                   full;
    ata_brtg_pkg::t_request req_bus = '0;
    logic                   empty;
    logic                   pop = 1'b0;
    ata_brtg_pkg::t_result  res_bus;
    logic                   cfg_we = 1'b0;
    logic [2:0]             cfg_idx = '0;
    logic [7:0]             cfg_wdata = '0;

    // mirror of the register file, reset values
    ata_brtg_pkg::t_cfg dev_cfg = '{use_lba: 1'b0, track_sectors: 8'd63, head_count: 5'd16,
                                    device_is_slave: 1'b0,
                                    device_kind: ata_brtg_pkg::KIND_ATA};

    ata_brtg_pkg::t_request req_pending[$];
    ata_brtg_pkg::t_result  expected_desc[$];

    int  n_queued = 0;
    int  n_accepted = 0;
    int  n_checked = 0;
    int  n_errors = 0;
    int  n_refused = 0;
    int  n_overflow = 0;
    int  n_full_cycles = 0;
    int  n_settings = 1;
    int  push_gap = 0;
    int  pop_wait = 0;
    logic quiet = 1'b0;
    logic long_stall_req = 1'b0;
    logic long_stall_taken = 1'b0;

    ata_block_request_taskfile_gen #(
        .MAX_BLOCKS(MAX_REQ_BLOCKS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_req      (req_bus),
        .empty      (empty),
        .pop        (pop),
        .o_res      (res_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_wdata(cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // expand one accepted request into the descriptors it should produce
    function automatic void predict_descriptors(ata_brtg_pkg::t_request r);
        ata_brtg_pkg::t_result d;
        logic [6:0]  n;
        logic [31:0] addr;
        logic [31:0] spt;
        logic [31:0] hds;
        logic [31:0] trk;
        logic [31:0] cyl;
        logic [7:0]  slave_bit;
        n = (r.block_count > MAX_REQ_BLOCKS) ? 7'(MAX_REQ_BLOCKS) : r.block_count;
        if (n == 0)
            return;
        slave_bit = dev_cfg.device_is_slave ? ata_brtg_pkg::DH_SLAVE : 8'h00;
        if (dev_cfg.device_kind == ata_brtg_pkg::KIND_ATAPI
            && r.op == ata_brtg_pkg::OP_WRITE) begin
            d = '0;
            d.status = ata_brtg_pkg::ST_REFUSED;
            d.last = 1'b1;
            expected_desc.push_back(d);
            n_refused++;
            return;
        end
        spt = (dev_cfg.track_sectors == 0) ? 32'd1 : 32'(dev_cfg.track_sectors);
        hds = (dev_cfg.head_count == 0) ? 32'd1 : 32'(dev_cfg.head_count);
        addr = r.start_block;
        for (int i = 0; i < n; i++) begin
            d = '0;
            d.last = (i == n - 1);
            if (dev_cfg.device_kind == ata_brtg_pkg::KIND_ATAPI) begin
                d.command = ata_brtg_pkg::CMD_PACKET;
                d.cylinder = ata_brtg_pkg::ATAPI_BYTES;
                d.drive_head = ata_brtg_pkg::DH_BASE | ata_brtg_pkg::DH_LBA | slave_bit;
                d.packet_block = addr;
            end else begin
                d.command = (r.op == ata_brtg_pkg::OP_WRITE) ? ata_brtg_pkg::CMD_WRITE
                                                             : ata_brtg_pkg::CMD_READ;
                if (dev_cfg.use_lba) begin
                    // bits 31:28 fall off silently
                    d.sector_number = addr[7:0];
                    d.cylinder = addr[23:8];
                    d.drive_head = ata_brtg_pkg::DH_BASE | ata_brtg_pkg::DH_LBA | slave_bit
                                   | {4'h0, addr[27:24]};
                end else begin
                    trk = addr / spt;
                    cyl = trk / hds;
                    d.sector_number = 8'((addr % spt) + 1);
                    d.drive_head = ata_brtg_pkg::DH_BASE | slave_bit | {4'h0, 4'(trk % hds)};
                    d.cylinder = cyl[15:0];
                    if (cyl > 32'hFFFF) begin
                        d.status = ata_brtg_pkg::ST_CYL_OVF;
                        n_overflow++;
                    end
                end
            end
            expected_desc.push_back(d);
            addr = addr + 32'd1;
        end
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            n_errors++;
            $display("%0t: descriptor %0d %s mismatch: expected %h, got %h",
                     $time, n_checked, name, want, got);
        end
    endfunction

    function automatic void check_descriptor(ata_brtg_pkg::t_result got);
        ata_brtg_pkg::t_result want;
        if (expected_desc.size() == 0) begin
            n_errors++;
            $display("%0t: unexpected descriptor: expected none, got %h", $time, got);
            return;
        end
        want = expected_desc.pop_front();
        compare_field("status", want.status, got.status);
        compare_field("command", want.command, got.command);
        compare_field("sector_number", want.sector_number, got.sector_number);
        compare_field("cylinder", want.cylinder, got.cylinder);
        compare_field("drive_head", want.drive_head, got.drive_head);
        compare_field("packet_block", want.packet_block, got.packet_block);
        compare_field("last", want.last, got.last);
        n_checked++;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
            push_gap <= 0;
        end else begin
            if (push && !full) begin
                predict_descriptors(req_bus);
                n_accepted <= n_accepted + 1;
            end
            if (push && full) begin
                // hold the request until the block takes it
                n_full_cycles <= n_full_cycles + 1;
            end else if (push_gap > 0) begin
                push_gap <= push_gap - 1;
                push <= 1'b0;
            end else if (req_pending.size() > 0) begin
                if (!quiet && $urandom_range(0, 7) == 0) begin
                    push_gap <= $urandom_range(0, 4);
                    push <= 1'b0;
                end else begin
                    req_bus <= req_pending.pop_front();
                    push <= 1'b1;
                end
            end else begin
                push <= 1'b0;
            end
        end
    end

    // descriptor monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
            pop_wait <= 0;
        end else begin
            if (pop && !empty)
                check_descriptor(res_bus);
            if (long_stall_req && !long_stall_taken) begin
                long_stall_taken <= 1'b1;
                pop_wait <= LONG_STALL_CYCLES;
                pop <= 1'b0;
            end else if (pop_wait > 0) begin
                pop_wait <= pop_wait - 1;
                pop <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                pop_wait <= $urandom_range(0, 4);
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [7:0] val);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            ata_brtg_pkg::CFG_USE_LBA: dev_cfg.use_lba = val[0];
            ata_brtg_pkg::CFG_SPT:     dev_cfg.track_sectors = val;
            ata_brtg_pkg::CFG_HEADS:   dev_cfg.head_count = val[4:0];
            ata_brtg_pkg::CFG_SLAVE:   dev_cfg.device_is_slave = val[0];
            ata_brtg_pkg::CFG_KIND:    dev_cfg.device_kind = val[0];
            default:     ;
        endcase
    endtask

    task automatic write_all(logic lba, logic [7:0] spt, logic [7:0] hds, logic slave,
                             logic kind);
        write_reg(ata_brtg_pkg::CFG_USE_LBA, {7'b0, lba});
        write_reg(ata_brtg_pkg::CFG_SPT, spt);
        write_reg(ata_brtg_pkg::CFG_HEADS, hds);
        write_reg(ata_brtg_pkg::CFG_SLAVE, {7'b0, slave});
        write_reg(ata_brtg_pkg::CFG_KIND, {7'b0, kind});
        n_settings++;
    endtask

    task automatic queue_req(logic op, logic [31:0] start, logic [6:0] count);
        ata_brtg_pkg::t_request r;
        r.op = op;
        r.start_block = start;
        r.block_count = count;
        req_pending.push_back(r);
        n_queued++;
    endtask

    // mostly short requests; a few long or oversized ones, and addresses that hit
    // the wrap point and the cylinder overflow edge
    task automatic queue_random(int n);
        int          sel;
        logic [6:0]  count;
        logic [31:0] start;
        longint      edge_addr;
        for (int k = 0; k < n; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 2)
                count = 7'd0;
            else if (sel < 70)
                count = 7'($urandom_range(1, 4));
            else if (sel < 90)
                count = 7'($urandom_range(5, 16));
            else if (sel < 97)
                count = 7'($urandom_range(17, 64));
            else
                count = 7'($urandom_range(65, 127));
            edge_addr = 64'd65536
                        * ((dev_cfg.track_sectors == 0) ? 1 : dev_cfg.track_sectors)
                        * ((dev_cfg.head_count == 0) ? 1 : dev_cfg.head_count);
            sel = $urandom_range(0, 9);
            if (sel < 4)
                start = $urandom;
            else if (sel < 6)
                start = $urandom_range(0, 32'hFFFF);
            else if (sel < 7)
                start = 32'hFFFF_FFFF - $urandom_range(0, 70);
            else if (edge_addr > 64'hFFFF_FF00)
                start = $urandom;
            else
                start = 32'(edge_addr - 200 + $urandom_range(0, 400));
            queue_req(1'($urandom_range(0, 1)), start, count);
        end
    endtask

    // wait for the sender to drain and every descriptor to come back
    task automatic settle();
        while (n_accepted != n_queued || expected_desc.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // chs 63 x 16 from reset: track and cylinder steps, overflow edge, wrap,
        // zero count, oversized counts
        queue_req(ata_brtg_pkg::OP_READ, 32'd0, 7'd1);
        queue_req(ata_brtg_pkg::OP_WRITE, 32'd62, 7'd3);
        queue_req(ata_brtg_pkg::OP_READ, 32'd1007, 7'd2);
        queue_req(ata_brtg_pkg::OP_READ, 32'd66060286, 7'd4);
        queue_req(ata_brtg_pkg::OP_WRITE, 32'hFFFF_FFFF, 7'd2);
        queue_req(ata_brtg_pkg::OP_READ, 32'h1234_5678, 7'd0);
        queue_req(ata_brtg_pkg::OP_READ, 32'd100, 7'd127);
        queue_req(ata_brtg_pkg::OP_WRITE, 32'd5000, 7'd64);
        queue_req(ata_brtg_pkg::OP_READ, 32'd20000, 7'd65);
        queue_random(22);
        settle();

        // lba on slave; receiver holds off so the block backs up into full
        write_all(1'b1, 8'd63, 8'd16, 1'b1, ata_brtg_pkg::KIND_ATA);
        long_stall_req = 1'b1;
        queue_req(ata_brtg_pkg::OP_READ, 32'hF123_4567, 7'd1);
        queue_req(ata_brtg_pkg::OP_WRITE, 32'h0FFF_FFFF, 7'd2);
        queue_req(ata_brtg_pkg::OP_READ, 32'hFFFF_FFFF, 7'd3);
        queue_req(ata_brtg_pkg::OP_WRITE, 32'd0, 7'd1);
        queue_random(20);
        settle();

        // atapi: packet reads, refused writes
        write_all(1'b0, 8'd63, 8'd16, 1'b0, ata_brtg_pkg::KIND_ATAPI);
        queue_req(ata_brtg_pkg::OP_READ, 32'hFFFF_FFFE, 7'd4);
        queue_req(ata_brtg_pkg::OP_WRITE, 32'd5, 7'd10);
        queue_req(ata_brtg_pkg::OP_WRITE, 32'd5, 7'd0);
        queue_req(ata_brtg_pkg::OP_WRITE, 32'hFFFF_FFFF, 7'd127);
        queue_req(ata_brtg_pkg::OP_READ, 32'd0, 7'd1);
        queue_random(25);
        settle();

        // zero divisors behave as one, so the cylinder is the address itself
        write_all(1'b0, 8'd0, 8'd0, 1'b1, ata_brtg_pkg::KIND_ATA);
        write_reg(CFG_UNUSED, 8'hFF);
        queue_req(ata_brtg_pkg::OP_READ, 32'd65534, 7'd3);
        queue_req(ata_brtg_pkg::OP_WRITE, 32'd1000, 7'd2);
        queue_random(25);
        settle();

        // widest geometry, head count masked to 31 so heads above 15 show up
        write_all(1'b0, 8'hFF, 8'hFF, 1'b0, ata_brtg_pkg::KIND_ATA);
        queue_req(ata_brtg_pkg::OP_READ, 32'd4335, 7'd2);
        queue_req(ata_brtg_pkg::OP_WRITE, 32'd518062079, 7'd2);
        queue_random(25);
        settle();

        write_all(1'b0, 8'd1, 8'd1, 1'b1, ata_brtg_pkg::KIND_ATA);
        queue_random(25);
        settle();

        write_all(1'b0, 8'd17, 8'd5, 1'b0, ata_brtg_pkg::KIND_ATA);
        queue_random(25);
        settle();

        write_all(1'b1, 8'd200, 8'd3, 1'b1, ata_brtg_pkg::KIND_ATAPI);
        queue_random(25);
        settle();

        write_all(1'b1, 8'd63, 8'd16, 1'b0, ata_brtg_pkg::KIND_ATA);
        queue_random(30);
        settle();

        // closing stretch at full rate on both sides
        write_all(1'b0, 8'd63, 8'd16, 1'b0, ata_brtg_pkg::KIND_ATA);
        quiet = 1'b1;
        queue_random(26);
        settle();

        $display("tb: %0d requests over %0d register settings, %0d descriptors checked",
                 n_accepted, n_settings, n_checked);
        $display("tb: %0d atapi write refusals, %0d cylinder overflows, %0d cycles held by full",
                 n_refused, n_overflow, n_full_cycles);
        if (n_errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // even with every request a 64-block chs walk a correct run finishes before this timeout
    initial begin
        #100ms;
        $display("%0t: timeout with %0d descriptors still expected", $time, expected_desc.size());
        $display("tb: FAIL");
        $finish;
    end

endmodule

FILE: files.f
rtl/ata_brtg_pkg.sv
rtl/ata_brtg_fifo.sv
rtl/ata_brtg_front.sv
rtl/ata_brtg_div.sv
rtl/ata_brtg_back.sv
rtl/ata_block_request_taskfile_gen.sv
rtl/ata_brtg_chk.sv
tb/tb.sv
